### src/assert_macros.svh
// Assertion helper macros for the I/Q discriminator checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define IQD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs across reset.
`define IQD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/iqd_pkg.sv
// Shared types, constants and the arctangent table of the I/Q discriminator.
// No dependencies; imported by all RTL modules of the block.
package iqd_pkg;

  // Default sizing handed to the top-level parameters, and the arctangent table depth
  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_DEPTH        = 24;

  // Fixed-point formats
  localparam int unsigned GUARD_BITS   = 8;
  localparam int unsigned ANGLE_WIDTH  = 32;
  localparam int unsigned PHASE_WIDTH  = 16;
  localparam int unsigned DEMOD_WIDTH  = 16;
  localparam int unsigned GAIN_WIDTH   = 16;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [ANGLE_WIDTH-1:0] ANGLE_PI     = 32'h8000_0000;
  localparam logic [ANGLE_WIDTH-1:0] PHASE_ROUND  = 32'h0000_8000;
  localparam logic [15:0]            MAG_GAIN_Q16 = 16'd39797;
  localparam logic [GAIN_WIDTH-1:0]  GAIN_RESET   = 16'd10923;

  // Register indexes of the configuration port
  typedef enum logic {
    CFG_DEMOD_MODE     = 1'b0,
    CFG_DEVIATION_GAIN = 1'b1
  } cfg_index_e;

  typedef enum logic {
    MODE_FM = 1'b0,
    MODE_AM = 1'b1
  } demod_mode_e;

  // Configuration as seen by the back end
  typedef struct packed {
    demod_mode_e                 mode;
    logic [GAIN_WIDTH-1:0]       gain;
  } cfg_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [ANGLE_WIDTH-1:0] atan_angle(input logic [4:0] idx);
    logic [ANGLE_WIDTH-1:0] a;
    unique case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### src/iqd_prerot.sv
// Input stage: scales the sample into the CORDIC format and folds the left
// half plane onto the right one. Depends on iqd_pkg.
module iqd_prerot import iqd_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned XY_WIDTH     = SAMPLE_WIDTH_DEF + GUARD_BITS + 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [SAMPLE_WIDTH-1:0]    sample_i_i,
  input  logic [SAMPLE_WIDTH-1:0]    sample_q_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [XY_WIDTH-1:0] x_o,
  output logic signed [XY_WIDTH-1:0] y_o,
  output logic [ANGLE_WIDTH-1:0]     z_o
);

  localparam int unsigned EXT_BITS = XY_WIDTH - SAMPLE_WIDTH - GUARD_BITS;

  logic signed [XY_WIDTH-1:0] x_ext, y_ext;
  logic signed [XY_WIDTH-1:0] x_d, x_q, y_d, y_q;
  logic [ANGLE_WIDTH-1:0]     z_d, z_q;
  logic                       valid_q;
  logic                       en;

  assign en      = ~valid_q | ready_i;
  assign ready_o = en;

  // Sign extend and scale by the guard bits
  assign x_ext = {{EXT_BITS{sample_i_i[SAMPLE_WIDTH-1]}}, sample_i_i, {GUARD_BITS{1'b0}}};
  assign y_ext = {{EXT_BITS{sample_q_i[SAMPLE_WIDTH-1]}}, sample_q_i, {GUARD_BITS{1'b0}}};

  // Negative I: rotate by pi first
  always_comb begin
    if (x_ext[XY_WIDTH-1]) begin
      x_d = -x_ext;
      y_d = -y_ext;
      z_d = ANGLE_PI;
    end else begin
      x_d = x_ext;
      y_d = y_ext;
      z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

### src/iqd_cordic_stage.sv
// One registered vectoring CORDIC micro-rotation toward y = 0.
// Depends on iqd_pkg for the arctangent table.
module iqd_cordic_stage import iqd_pkg::*; #(
  parameter int unsigned STAGE    = 0,
  parameter int unsigned XY_WIDTH = SAMPLE_WIDTH_DEF + GUARD_BITS + 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic signed [XY_WIDTH-1:0] x_i,
  input  logic signed [XY_WIDTH-1:0] y_i,
  input  logic [ANGLE_WIDTH-1:0]     z_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [XY_WIDTH-1:0] x_o,
  output logic signed [XY_WIDTH-1:0] y_o,
  output logic [ANGLE_WIDTH-1:0]     z_o
);

  localparam logic [ANGLE_WIDTH-1:0] ATAN_STEP = atan_angle(5'(STAGE));

  logic signed [XY_WIDTH-1:0] xs, ys;
  logic signed [XY_WIDTH-1:0] x_d, x_q, y_d, y_q;
  logic [ANGLE_WIDTH-1:0]     z_d, z_q;
  logic                       valid_q;
  logic                       en;

  assign en      = ~valid_q | ready_i;
  assign ready_o = en;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  // Rotate direction follows the sign of y
  always_comb begin
    if (!y_i[XY_WIDTH-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN_STEP;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

### src/iqd_post.sv
// Back end: phase differencing, gain and magnitude multipliers, saturation
// and the output register. Depends on iqd_pkg.
module iqd_post import iqd_pkg::*; #(
  parameter int unsigned XY_WIDTH = SAMPLE_WIDTH_DEF + GUARD_BITS + 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic signed [XY_WIDTH-1:0] x_i,
  input  logic [ANGLE_WIDTH-1:0]     z_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [DEMOD_WIDTH-1:0]     data_o
);

  localparam int unsigned MAG_WIDTH  = XY_WIDTH - 1;
  localparam int unsigned AMP_WIDTH  = MAG_WIDTH + 16;
  localparam int unsigned FMP_WIDTH  = PHASE_WIDTH + GAIN_WIDTH + 1;
  localparam logic signed [FMP_WIDTH-1:0] FM_MAX = FMP_WIDTH'(32767);
  localparam logic signed [FMP_WIDTH-1:0] FM_MIN = -FMP_WIDTH'(32768);
  localparam logic [63:0] AM_ROUND = 64'd1 << (15 + GUARD_BITS);
  localparam logic [63:0] AM_MAX   = 64'd32767;

  // Stage 1: phase and wrapped difference
  logic                          v1_q, en1;
  demod_mode_e                   mode1_q;
  logic [PHASE_WIDTH-1:0]        delta1_d, delta1_q;
  logic [MAG_WIDTH-1:0]          mag1_d, mag1_q;
  logic [ANGLE_WIDTH-1:0]        z_rnd;
  logic [PHASE_WIDTH-1:0]        phase, prev_d, prev_q;

  // Stage 2: products
  logic                          v2_q, en2;
  demod_mode_e                   mode2_q;
  logic signed [FMP_WIDTH-1:0]   fm_prod_d, fm_prod_q;
  logic [AMP_WIDTH-1:0]          am_prod_d, am_prod_q;

  // Stage 3: output register
  logic                          v3_q, en3;
  logic signed [FMP_WIDTH-1:0]   fm_shift;
  logic [63:0]                   am_sum, am_mag;
  logic [DEMOD_WIDTH-1:0]        data_d, data_q;

  assign en3     = ~v3_q | ready_i;
  assign en2     = ~v2_q | en3;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;

  // Phase rounded to 16 bits; difference wraps modulo 2^16
  assign z_rnd    = z_i + PHASE_ROUND;
  assign phase    = z_rnd[ANGLE_WIDTH-1:ANGLE_WIDTH-PHASE_WIDTH];
  assign delta1_d = phase - prev_q;
  assign mag1_d   = x_i[XY_WIDTH-1] ? '0 : x_i[MAG_WIDTH-1:0];

  // Stored phase advances only on FM samples
  always_comb begin
    prev_d = prev_q;
    if (en1 && valid_i && (cfg_i.mode == MODE_FM)) begin
      prev_d = phase;
    end
  end

  // Multipliers
  assign fm_prod_d = $signed({{(FMP_WIDTH-PHASE_WIDTH){delta1_q[PHASE_WIDTH-1]}}, delta1_q})
                   * $signed({{(FMP_WIDTH-GAIN_WIDTH){1'b0}}, cfg_i.gain});
  assign am_prod_d = AMP_WIDTH'(mag1_q) * AMP_WIDTH'(MAG_GAIN_Q16);

  // Shift, round the AM magnitude and saturate
  assign fm_shift = fm_prod_q >>> 16;
  assign am_sum   = 64'(am_prod_q) + AM_ROUND;
  assign am_mag   = am_sum >> (16 + GUARD_BITS);

  always_comb begin
    if (mode2_q == MODE_AM) begin
      data_d = (am_mag > AM_MAX) ? DEMOD_WIDTH'(AM_MAX) : am_mag[DEMOD_WIDTH-1:0];
    end else if (fm_shift > FM_MAX) begin
      data_d = FM_MAX[DEMOD_WIDTH-1:0];
    end else if (fm_shift < FM_MIN) begin
      data_d = FM_MIN[DEMOD_WIDTH-1:0];
    end else begin
      data_d = fm_shift[DEMOD_WIDTH-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      mode1_q  <= cfg_i.mode;
      delta1_q <= delta1_d;
      mag1_q   <= mag1_d;
    end
    if (en2 && v1_q) begin
      mode2_q   <= mode1_q;
      fm_prod_q <= fm_prod_d;
      am_prod_q <= am_prod_d;
    end
    if (en3 && v2_q) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = data_q;

endmodule

### src/fm_am_iq_discriminator.sv
// Polar FM discriminator / AM envelope detector, top level.
// Depends on iqd_pkg, iqd_prerot, iqd_cordic_stage and iqd_post.
//
// Takes one signed I/Q sample per clock and returns one demodulated value per
// sample, in order. A CORDIC_STAGES-deep vectoring CORDIC gives phase and
// magnitude; FM mode scales the wrapped phase step by deviation_gain, AM mode
// gives the gain-corrected magnitude, both saturated to 16 bits. Throughput is
// one sample per cycle while the output is not stalled. The input stage, one
// register per CORDIC stage and three back-end stages each hold their data
// under backpressure and bubbles close up, so a stalled output loses nothing.
// Write the configuration registers only while no sample is in flight.
module fm_am_iq_discriminator import iqd_pkg::*; #(
  parameter  int unsigned SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter  int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF,
  localparam int unsigned IN_TDATA_W    = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Sample stream
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata_i,   // sample_i, sample_q, zero pad
  // Result stream
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [DEMOD_WIDTH-1:0]  m_axis_tdata_o,   // demod_value
  // Configuration writes
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned XY_WIDTH = SAMPLE_WIDTH + GUARD_BITS + 3;

  cfg_t cfg_d, cfg_q;

  logic                       valid_s [CORDIC_STAGES+1];
  logic                       ready_s [CORDIC_STAGES+1];
  logic signed [XY_WIDTH-1:0] x_s     [CORDIC_STAGES+1];
  logic signed [XY_WIDTH-1:0] y_s     [CORDIC_STAGES+1];
  logic [ANGLE_WIDTH-1:0]     z_s     [CORDIC_STAGES+1];

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_DEMOD_MODE:     cfg_d.mode = demod_mode_e'(cfg_wdata_i[0]);
        CFG_DEVIATION_GAIN: cfg_d.gain = cfg_wdata_i[GAIN_WIDTH-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= MODE_FM;
      cfg_q.gain <= GAIN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input scaling and half-plane fold
  iqd_prerot #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .XY_WIDTH     (XY_WIDTH)
  ) u_prerot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .sample_i_i (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .sample_q_i (s_axis_tdata_i[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .valid_o    (valid_s[0]),
    .ready_i    (ready_s[0]),
    .x_o        (x_s[0]),
    .y_o        (y_s[0]),
    .z_o        (z_s[0])
  );

  // CORDIC stage chain
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    iqd_cordic_stage #(
      .STAGE    (g),
      .XY_WIDTH (XY_WIDTH)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .x_i     (x_s[g]),
      .y_i     (y_s[g]),
      .z_i     (z_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .x_o     (x_s[g+1]),
      .y_o     (y_s[g+1]),
      .z_o     (z_s[g+1])
    );
  end

  // Phase difference / magnitude back end
  iqd_post #(
    .XY_WIDTH (XY_WIDTH)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (valid_s[CORDIC_STAGES]),
    .ready_o (ready_s[CORDIC_STAGES]),
    .x_i     (x_s[CORDIC_STAGES]),
    .z_i     (z_s[CORDIC_STAGES]),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

  // y of the last stage is not needed
  logic unused_y;
  assign unused_y = ^y_s[CORDIC_STAGES];

endmodule

### src/iqd_checker.sv
// Port-level checker for the I/Q discriminator, bound to the top level.
// Depends on iqd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iqd_checker import iqd_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_ready_i,
  input logic                   m_valid_i,
  input logic                   m_ready_i,
  input logic [DEMOD_WIDTH-1:0] m_data_i
);

  // Result transaction holds while stalled
  `IQD_ASSERT(a_out_valid_hold, clk_i, rst_ni, m_valid_i && !m_ready_i |=> m_valid_i, "output valid dropped under stall")
  `IQD_ASSERT(a_out_data_hold, clk_i, rst_ni, m_valid_i && !m_ready_i |=> $stable(m_data_i), "output data changed under stall")

  // Input backpressure only comes from a stalled output
  `IQD_ASSERT(a_ready_only_on_stall, clk_i, rst_ni, !s_ready_i |-> m_valid_i && !m_ready_i, "input refused while output not stalled")

  // Pipeline is empty right after reset
  `IQD_ASSERT_NR(a_empty_after_reset, clk_i, $rose(rst_ni) |-> (!m_valid_i && s_ready_i), "pipeline not empty after reset")

endmodule

bind fm_am_iq_discriminator iqd_checker u_iqd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_ready_i (s_axis_tready_o),
  .m_valid_i (m_axis_tvalid_o),
  .m_ready_i (m_axis_tready_i),
  .m_data_i  (m_axis_tdata_o)
);
